/* hdl/vg3_pkg.sv */
// ----------------------------------------------------------------------------
// vg3_pkg
// Shared types, constants and arithmetic helpers of the 3-D volume gradient.
// ----------------------------------------------------------------------------
package vg3_pkg;

  // Field and register widths
  localparam int VAL_W      = 24;
  localparam int ENTRY_W    = VAL_W + 1;          // null flag on top of the value
  localparam int GRAD_W     = 48;
  localparam int SCALE_W    = 32;
  localparam int DIFF_W     = 28;                 // holds +/- 2^26
  localparam int PROD_W     = DIFF_W + SCALE_W + 1;
  localparam int SIZE_XY_W  = 7;
  localparam int SIZE_Z_W   = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Default geometry
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_PLANES = 1024;
  localparam int RING_PLANES    = 4;
  localparam int RING_W         = 2;
  localparam int MIN_SIZE       = 3;
  localparam int RESET_SIZE     = 64;
  localparam logic [SCALE_W-1:0] RESET_SCALE = 32'd32768;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_X  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Y  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Z  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_X = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_Z = 3'd5;

  // Input opcodes
  localparam logic OP_VOXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Difference kind per axis
  localparam logic [1:0] MODE_CENTRAL = 2'd0;
  localparam logic [1:0] MODE_FWD     = 2'd1;
  localparam logic [1:0] MODE_BWD     = 2'd2;

  // Read slots carried with each item
  localparam int NRD    = 7;
  localparam int RD_CTR = 0;
  localparam int RD_XA  = 1;
  localparam int RD_XB  = 2;
  localparam int RD_YA  = 3;
  localparam int RD_YB  = 4;
  localparam int RD_ZA  = 5;
  localparam int RD_ZB  = 6;

  localparam int RAM_COPIES = 4;
  localparam int OUT_DEPTH  = 4;

  // Control part of one queued item
  typedef struct packed {
    logic       wr;
    logic       emit;
    logic       last;
    logic [1:0] mode_x;
    logic [1:0] mode_y;
    logic [1:0] mode_z;
  } vg3_ctrl_t;

  localparam int CTRL_W = $bits(vg3_ctrl_t);

  // One-axis difference over three ring entries; zero when any is null.
  // Central: ra = pos-1, rb = pos+1. Forward: c, ra, rb = 0, 1, 2.
  // Backward: ra, rb, c = n-3, n-2, n-1.
  function automatic logic signed [DIFF_W-1:0] axis_diff(
    input logic [1:0]         mode,
    input logic [ENTRY_W-1:0] c,
    input logic [ENTRY_W-1:0] ra,
    input logic [ENTRY_W-1:0] rb
  );
    logic signed [DIFF_W-1:0] vc, va, vb, d;
    vc = DIFF_W'($signed(c[VAL_W-1:0]));
    va = DIFF_W'($signed(ra[VAL_W-1:0]));
    vb = DIFF_W'($signed(rb[VAL_W-1:0]));
    unique case (mode)
      MODE_CENTRAL: d = vb - va;
      MODE_FWD:     d = (va <<< 2) - (vc <<< 1) - vc - vb;
      MODE_BWD:     d = (vc <<< 1) + vc - (vb <<< 2) + va;
      default:      d = '0;
    endcase
    if (c[VAL_W] || ra[VAL_W] || rb[VAL_W]) begin
      d = '0;
    end
    return d;
  endfunction

  // Clamp a product to the signed gradient range
  function automatic logic [GRAD_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
    logic all_one, all_zero;
    all_one  = &p[PROD_W-1:GRAD_W-1];
    all_zero = ~|p[PROD_W-1:GRAD_W-1];
    if (all_one || all_zero) begin
      return p[GRAD_W-1:0];
    end else if (p[PROD_W-1]) begin
      return {1'b1, {(GRAD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(GRAD_W-1){1'b1}}};
    end
  endfunction

endpackage

/* hdl/volume_gradient_3d.sv */
// ----------------------------------------------------------------------------
// volume_gradient_3d
// Streaming second-order x/y/z gradient of a raster-ordered voxel volume.
//
//  channel | dir | payload                                   | handshake
//  in_     | in  | tdata: voxel_value; tuser: opcode, null   | tvalid/tready
//  out_    | out | tdata: grad_east, north, up; tuser: null  | tvalid/tready
//  cfg_    | in  | index + 32-bit data                       | cfg_we only
//
// Each result needs seven ring reads from four RAM copies with one read port
// each: in-plane taps first, then centre and z taps; no job starts in between.
// A result passes the job queue, difference, scaling and result FIFO registers.
// Reset is synchronous; the ring needs no clearing pass after reset.
// The front keeps taking transfers into a 2-entry queue while the output
// stalls, until that queue is full; a 4-entry result FIFO holds finished results.
// ----------------------------------------------------------------------------
module volume_gradient_3d #(
  parameter int MAX_COLS   = vg3_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = vg3_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES = vg3_pkg::DEF_MAX_PLANES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vg3_pkg::VAL_W-1:0]         in_tdata,   // [23:0] voxel_value
  input  logic [1:0]                        in_tuser,   // [0] opcode, [1] voxel_null
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [3*vg3_pkg::GRAD_W-1:0]      out_tdata,  // grad_east, grad_north, grad_up
  output logic                              out_tuser,  // [0] result_null
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [vg3_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [vg3_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import vg3_pkg::*;

  localparam int CB = $clog2(MAX_COLS);
  localparam int RB = $clog2(MAX_ROWS);
  localparam int XW = $clog2(MAX_COLS + 1);
  localparam int YW = $clog2(MAX_ROWS + 1);
  localparam int PW = $clog2(MAX_PLANES + 1);
  localparam int AW = RING_W + RB + CB;
  localparam int QW = CTRL_W + ENTRY_W + AW + NRD * AW;
  localparam int RST_X = (RESET_SIZE > MAX_COLS) ? MAX_COLS : RESET_SIZE;
  localparam int RST_Y = (RESET_SIZE > MAX_ROWS) ? MAX_ROWS : RESET_SIZE;
  localparam int RST_Z = (RESET_SIZE > MAX_PLANES) ? MAX_PLANES : RESET_SIZE;

  logic [XW-1:0]      ex_r;
  logic [YW-1:0]      ey_r;
  logic [PW-1:0]      ez_r;
  logic [SCALE_W-1:0] scale_x_r, scale_y_r, scale_z_r;
  logic               size_wr;
  logic [SIZE_XY_W-1:0] wx, wy;
  logic [SIZE_Z_W-1:0]  wz;
  logic [XW-1:0]      ex_nxt;
  logic [YW-1:0]      ey_nxt;
  logic [PW-1:0]      ez_nxt;

  logic                   f_push, q_full, q_empty, q_pop;
  vg3_ctrl_t              f_ctrl, q_ctrl;
  logic [AW-1:0]          f_waddr, q_waddr;
  logic [ENTRY_W-1:0]     f_wdata, q_wdata;
  logic [NRD-1:0][AW-1:0] f_raddr, q_raddr;
  logic [QW-1:0]          q_rd;

  // Size writes restart the volume
  assign size_wr = cfg_we && (cfg_addr == REG_SIZE_X || cfg_addr == REG_SIZE_Y ||
                              cfg_addr == REG_SIZE_Z);
  assign wx = cfg_wdata[SIZE_XY_W-1:0];
  assign wy = cfg_wdata[SIZE_XY_W-1:0];
  assign wz = cfg_wdata[SIZE_Z_W-1:0];

  // Clamp sizes into the supported range
  always_comb begin
    if (32'(wx) < 32'(MIN_SIZE))      ex_nxt = XW'(MIN_SIZE);
    else if (32'(wx) > 32'(MAX_COLS)) ex_nxt = XW'(MAX_COLS);
    else                              ex_nxt = XW'(wx);
    if (32'(wy) < 32'(MIN_SIZE))      ey_nxt = YW'(MIN_SIZE);
    else if (32'(wy) > 32'(MAX_ROWS)) ey_nxt = YW'(MAX_ROWS);
    else                              ey_nxt = YW'(wy);
    if (32'(wz) < 32'(MIN_SIZE))        ez_nxt = PW'(MIN_SIZE);
    else if (32'(wz) > 32'(MAX_PLANES)) ez_nxt = PW'(MAX_PLANES);
    else                                ez_nxt = PW'(wz);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_r      <= XW'(RST_X);
      ey_r      <= YW'(RST_Y);
      ez_r      <= PW'(RST_Z);
      scale_x_r <= RESET_SCALE;
      scale_y_r <= RESET_SCALE;
      scale_z_r <= RESET_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SIZE_X:  ex_r      <= ex_nxt;
        REG_SIZE_Y:  ey_r      <= ey_nxt;
        REG_SIZE_Z:  ez_r      <= ez_nxt;
        REG_SCALE_X: scale_x_r <= cfg_wdata;
        REG_SCALE_Y: scale_y_r <= cfg_wdata;
        REG_SCALE_Z: scale_z_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  vg3_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .MAX_PLANES(MAX_PLANES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_opcode(in_tuser[0]),
    .in_value (in_tdata),
    .in_null  (in_tuser[1]),
    .ex       (ex_r),
    .ey       (ey_r),
    .ez       (ez_r),
    .clear    (size_wr),
    .q_full   (q_full),
    .push     (f_push),
    .ctrl     (f_ctrl),
    .waddr    (f_waddr),
    .wdata    (f_wdata),
    .raddr    (f_raddr)
  );

  // Job queue between front and back
  vg3_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_job_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (f_push),
    .wr_data({f_ctrl, f_wdata, f_waddr, f_raddr}),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rd),
    .empty  (q_empty)
  );

  assign {q_ctrl, q_wdata, q_waddr, q_raddr} = q_rd;

  vg3_back #(
    .AW(AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(!q_empty),
    .ctrl      (q_ctrl),
    .waddr     (q_waddr),
    .wdata     (q_wdata),
    .raddr     (q_raddr),
    .item_pop  (q_pop),
    .scale_x   (scale_x_r),
    .scale_y   (scale_y_r),
    .scale_z   (scale_z_r),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

/* hdl/vg3_ram.sv */
// ----------------------------------------------------------------------------
// vg3_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vg3_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/vg3_fifo.sv */
// ----------------------------------------------------------------------------
// vg3_fifo
// Small register FIFO with first-word-fall-through read.
// ----------------------------------------------------------------------------
module vg3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(wr_en) - CW'(rd_en);
    end
  end

endmodule

/* hdl/vg3_front.sv */
// ----------------------------------------------------------------------------
// vg3_front
// Accepts voxels and drain items, tracks input and output raster positions
// and turns each transfer into a ring write, a gradient job, both or neither.
// ----------------------------------------------------------------------------
module vg3_front #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_PLANES = 1024,
  parameter int CB = $clog2(MAX_COLS),
  parameter int RB = $clog2(MAX_ROWS),
  parameter int XW = $clog2(MAX_COLS + 1),
  parameter int YW = $clog2(MAX_ROWS + 1),
  parameter int PW = $clog2(MAX_PLANES + 1),
  parameter int AW = vg3_pkg::RING_W + RB + CB
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_opcode,
  input  logic [vg3_pkg::VAL_W-1:0]             in_value,
  input  logic                                  in_null,
  input  logic [XW-1:0]                         ex,
  input  logic [YW-1:0]                         ey,
  input  logic [PW-1:0]                         ez,
  input  logic                                  clear,
  input  logic                                  q_full,
  output logic                                  push,
  output vg3_pkg::vg3_ctrl_t                    ctrl,
  output logic [AW-1:0]                         waddr,
  output logic [vg3_pkg::ENTRY_W-1:0]           wdata,
  output logic [vg3_pkg::NRD-1:0][AW-1:0]       raddr
);
  import vg3_pkg::*;

  logic [CB-1:0] in_col_r, out_col_r;
  logic [RB-1:0] in_row_r, out_row_r;
  logic [PW-1:0] in_plane_r, out_plane_r;

  logic accept, complete, is_drain, do_wr, do_emit, last;
  logic col_end, row_end;
  logic [1:0] mx, my, mz;
  logic [31:0] xa, xb, ya, yb, za, zb;
  logic [RING_W-1:0] pc, pa, pb;

  function automatic logic [1:0] mode_of(input logic [31:0] pos, input logic [31:0] n);
    if (pos == 32'd0) begin
      return MODE_FWD;
    end else if (pos >= n - 32'd1) begin
      return MODE_BWD;
    end else begin
      return MODE_CENTRAL;
    end
  endfunction

  // Neighbor position: first or second of the two non-centre taps
  function automatic logic [31:0] nb_pos(input logic [1:0] mode, input logic [31:0] pos,
                                         input logic [31:0] n, input logic second);
    logic [31:0] r;
    unique case (mode)
      MODE_FWD: r = second ? 32'd2 : 32'd1;
      MODE_BWD: r = second ? n - 32'd2 : n - 32'd3;
      default:  r = second ? pos + 32'd1 : pos - 32'd1;
    endcase
    return r;
  endfunction

  // Classify the transfer
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign complete = (in_plane_r == ez);
  assign is_drain = (in_opcode == OP_DRAIN);
  assign do_wr    = !is_drain && !complete;
  assign do_emit  = is_drain ? complete : (!complete && (in_plane_r >= PW'(2)));
  assign push     = accept && (do_wr || do_emit);

  assign last = (XW'(out_col_r) == ex - XW'(1)) && (YW'(out_row_r) == ey - YW'(1)) &&
                (out_plane_r == ez - PW'(1));

  // Tap positions around the output voxel
  always_comb begin
    mx = mode_of(32'(out_col_r), 32'(ex));
    my = mode_of(32'(out_row_r), 32'(ey));
    mz = mode_of(32'(out_plane_r), 32'(ez));
    xa = nb_pos(mx, 32'(out_col_r), 32'(ex), 1'b0);
    xb = nb_pos(mx, 32'(out_col_r), 32'(ex), 1'b1);
    ya = nb_pos(my, 32'(out_row_r), 32'(ey), 1'b0);
    yb = nb_pos(my, 32'(out_row_r), 32'(ey), 1'b1);
    za = nb_pos(mz, 32'(out_plane_r), 32'(ez), 1'b0);
    zb = nb_pos(mz, 32'(out_plane_r), 32'(ez), 1'b1);
    pc = out_plane_r[RING_W-1:0];
    pa = za[RING_W-1:0];
    pb = zb[RING_W-1:0];
  end

  // Job built from the transfer
  always_comb begin
    ctrl.wr     = do_wr;
    ctrl.emit   = do_emit;
    ctrl.last   = last;
    ctrl.mode_x = mx;
    ctrl.mode_y = my;
    ctrl.mode_z = mz;
    waddr       = {in_plane_r[RING_W-1:0], in_row_r, in_col_r};
    wdata       = {in_null, in_value};
    raddr[RD_CTR] = {pc, out_row_r, out_col_r};
    raddr[RD_XA]  = {pc, out_row_r, xa[CB-1:0]};
    raddr[RD_XB]  = {pc, out_row_r, xb[CB-1:0]};
    raddr[RD_YA]  = {pc, ya[RB-1:0], out_col_r};
    raddr[RD_YB]  = {pc, yb[RB-1:0], out_col_r};
    raddr[RD_ZA]  = {pa, out_row_r, out_col_r};
    raddr[RD_ZB]  = {pb, out_row_r, out_col_r};
  end

  assign col_end = (XW'(in_col_r) + XW'(1) == ex);
  assign row_end = (YW'(in_row_r) + YW'(1) == ey);

  // Raster counters
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_plane_r  <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_plane_r <= '0;
    end else if (accept) begin
      if (do_wr) begin
        in_col_r <= col_end ? '0 : in_col_r + CB'(1);
        if (col_end) begin
          in_row_r <= row_end ? '0 : in_row_r + RB'(1);
          if (row_end) begin
            in_plane_r <= in_plane_r + PW'(1);
          end
        end
      end
      if (do_emit) begin
        if (last) begin
          in_col_r    <= '0;
          in_row_r    <= '0;
          in_plane_r  <= '0;
          out_col_r   <= '0;
          out_row_r   <= '0;
          out_plane_r <= '0;
        end else begin
          out_col_r <= (XW'(out_col_r) + XW'(1) == ex) ? '0 : out_col_r + CB'(1);
          if (XW'(out_col_r) + XW'(1) == ex) begin
            out_row_r <= (YW'(out_row_r) + YW'(1) == ey) ? '0 : out_row_r + RB'(1);
            if (YW'(out_row_r) + YW'(1) == ey) begin
              out_plane_r <= out_plane_r + PW'(1);
            end
          end
        end
      end
    end
  end

endmodule

/* hdl/vg3_back.sv */
// ----------------------------------------------------------------------------
// vg3_back
// Executes queued jobs: ring write, seven ring reads from four RAM copies,
// differences, scaling, saturation and result FIFO.
// ----------------------------------------------------------------------------
module vg3_back #(
  parameter int AW = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  item_valid,
  input  vg3_pkg::vg3_ctrl_t                    ctrl,
  input  logic [AW-1:0]                         waddr,
  input  logic [vg3_pkg::ENTRY_W-1:0]           wdata,
  input  logic [vg3_pkg::NRD-1:0][AW-1:0]       raddr,
  output logic                                  item_pop,
  input  logic [vg3_pkg::SCALE_W-1:0]           scale_x,
  input  logic [vg3_pkg::SCALE_W-1:0]           scale_y,
  input  logic [vg3_pkg::SCALE_W-1:0]           scale_z,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [3*vg3_pkg::GRAD_W-1:0]          out_tdata,
  output logic                                  out_tuser,
  output logic                                  out_tlast
);
  import vg3_pkg::*;

  localparam int OW    = 3 * GRAD_W + 2;
  localparam int RESW  = $clog2(OUT_DEPTH + 1);

  logic              phase_r;
  vg3_ctrl_t         cur_ctrl_r, s2_ctrl_r;
  logic [AW-1:0]     cur_ctr_r, cur_za_r, cur_zb_r;
  logic [RESW-1:0]   res_r;
  logic              start, s2_v_r, s3_v_r, s4_v_r, out_xfer;

  logic [AW-1:0]      ram_raddr [RAM_COPIES];
  logic [ENTRY_W-1:0] ram_rdata [RAM_COPIES];
  logic [ENTRY_W-1:0] tap_r     [RAM_COPIES];

  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic                     null3_r, last3_r, null4_r, last4_r;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic [OW-1:0]            fifo_wdata, fifo_rdata;
  logic                     fifo_full, fifo_empty;

  // A job with a result starts only when a FIFO slot is reserved for it
  assign start    = item_valid && !phase_r && (!ctrl.emit || (res_r < RESW'(OUT_DEPTH)));
  assign item_pop = start;
  assign out_xfer = out_tvalid && out_tready;

  // Read address per copy: in-plane taps first, centre and z taps second
  always_comb begin
    if (phase_r) begin
      ram_raddr[0] = cur_ctr_r;
      ram_raddr[1] = cur_za_r;
      ram_raddr[2] = cur_zb_r;
      ram_raddr[3] = cur_ctr_r;
    end else begin
      ram_raddr[0] = raddr[RD_XA];
      ram_raddr[1] = raddr[RD_XB];
      ram_raddr[2] = raddr[RD_YA];
      ram_raddr[3] = raddr[RD_YB];
    end
  end

  // Plane ring, replicated for read bandwidth
  for (genvar g = 0; g < RAM_COPIES; g++) begin : g_ring
    vg3_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(2 ** AW)
    ) u_ram (
      .clk  (clk),
      .we   (start && ctrl.wr),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(ram_raddr[g]),
      .rdata(ram_rdata[g])
    );
  end

  // Job sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      res_r   <= '0;
    end else begin
      phase_r <= start ? ctrl.emit : 1'b0;
      s2_v_r  <= phase_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      res_r   <= res_r + RESW'(start && ctrl.emit) - RESW'(out_xfer);
    end
  end

  // Job payload and first tap group
  always_ff @(posedge clk) begin
    if (start) begin
      cur_ctrl_r <= ctrl;
      cur_ctr_r  <= raddr[RD_CTR];
      cur_za_r   <= raddr[RD_ZA];
      cur_zb_r   <= raddr[RD_ZB];
    end
    if (phase_r) begin
      s2_ctrl_r <= cur_ctrl_r;
      for (int k = 0; k < RAM_COPIES; k++) begin
        tap_r[k] <= ram_rdata[k];
      end
    end
  end

  // Differences; y is negated here
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      dx_r    <= axis_diff(s2_ctrl_r.mode_x, ram_rdata[0], tap_r[0], tap_r[1]);
      dy_r    <= -axis_diff(s2_ctrl_r.mode_y, ram_rdata[0], tap_r[2], tap_r[3]);
      dz_r    <= axis_diff(s2_ctrl_r.mode_z, ram_rdata[0], ram_rdata[1], ram_rdata[2]);
      null3_r <= ram_rdata[0][VAL_W];
      last3_r <= s2_ctrl_r.last;
    end
  end

  // Scaling
  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      px_r    <= PROD_W'(dx_r * $signed({1'b0, scale_x}));
      py_r    <= PROD_W'(dy_r * $signed({1'b0, scale_y}));
      pz_r    <= PROD_W'(dz_r * $signed({1'b0, scale_z}));
      null4_r <= null3_r;
      last4_r <= last3_r;
    end
  end

  assign fifo_wdata = {last4_r, null4_r, saturate(pz_r), saturate(py_r), saturate(px_r)};

  // Result buffer decouples the output stall from the datapath
  vg3_fifo #(
    .WIDTH(OW),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (s4_v_r && !fifo_full),
    .wr_data(fifo_wdata),
    .full   (fifo_full),
    .rd_en  (out_xfer),
    .rd_data(fifo_rdata),
    .empty  (fifo_empty)
  );

  assign out_tvalid = !fifo_empty;
  assign out_tdata  = fifo_rdata[3*GRAD_W-1:0];
  assign out_tuser  = fifo_rdata[3*GRAD_W];
  assign out_tlast  = fifo_rdata[3*GRAD_W+1];

endmodule

/* hdl/vg3_checker.sv */
// ----------------------------------------------------------------------------
// vg3_checker
// Port-level checks of the volume gradient block, bound to the top level.
// ----------------------------------------------------------------------------
module vg3_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tlast
);

  // A null centre carries zero gradients
  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("null result with nonzero gradient");

  // Nothing is shown right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The job queue is empty after reset, so input is taken at once
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind volume_gradient_3d vg3_checker u_vg3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
